/* sv/rlrsm_pkg.sv */
// ----------------------------------------------------------------------------
// rlrsm_pkg: shared types and constants for the row long-run span marker
// Word formats, configuration register indexes, reset values and helpers.
// ----------------------------------------------------------------------------
package rlrsm_pkg;

  // Default maximum row width in pixels
  localparam int unsigned MAX_WIDTH_DEF = 4096;

  // Field widths fixed by the word formats
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SPAN_W = 12;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned THR_W  = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_FLOOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_THRESHOLD  = 2'd3;

  // Register reset values
  localparam logic [LEN_W-1:0] LENGTH_FLOOR_RST    = 13'd15;
  localparam logic [THR_W-1:0] INTENSITY_FLOOR_RST = 9'd0;
  localparam logic [PIX_W-1:0] EDGE_THRESHOLD_RST  = 8'd50;
  localparam logic [THR_W-1:0] JOIN_THRESHOLD_RST  = 9'd150;

  // Largest intensity floor that still enables clearing
  localparam logic [THR_W-1:0] INTENSITY_MAX = 9'd255;

  // Input word
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_last;
  } in_t;

  // Result word
  typedef struct packed {
    logic              span_valid;
    logic [SPAN_W-1:0] span_first;
    logic [SPAN_W-1:0] span_final;
    logic              row_done;
  } out_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [LEN_W-1:0] length_floor;
    logic [THR_W-1:0] intensity_floor;
    logic [PIX_W-1:0] edge_threshold;
    logic [THR_W-1:0] join_threshold;
  } cfg_t;

  // Absolute difference of two pixel values
  function automatic logic [PIX_W-1:0] abs_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* sv/rlrsm_core.sv */
// ----------------------------------------------------------------------------
// rlrsm_core: per-pixel run tracking and span decision
// Holds the row state, decides run ends and joins for the current pixel and
// advances the state by one pixel on each step.
// ----------------------------------------------------------------------------
module rlrsm_core #(
  parameter int unsigned MAX_WIDTH = rlrsm_pkg::MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rlrsm_pkg::in_t   word,
  input  rlrsm_pkg::cfg_t  cfg,
  output rlrsm_pkg::out_t  res,
  output logic             res_hit
);
  import rlrsm_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W = (COL_W > LEN_W) ? COL_W : LEN_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

  // Row state
  logic [COL_W-1:0] column;
  logic [PIX_W-1:0] prior_pixel;
  logic [COL_W-1:0] run_begin;
  logic [PIX_W-1:0] run_begin_value;
  logic [COL_W-1:0] prev_run_end;
  logic [PIX_W-1:0] prev_run_end_value;
  logic             have_prev_run;

  logic             last;
  logic [PIX_W-1:0] begin_value;
  logic             run_end;
  logic [COL_W-1:0] run_len;
  logic             accept;
  logic             merge;
  logic [COL_W-1:0] first;
  logic             valid;

  // Decide run end, acceptance and join for the current pixel
  always_comb begin
    last        = word.row_last || (column == COL_LAST);
    begin_value = (column == run_begin) ? word.pixel : run_begin_value;
    run_end     = (column != '0) &&
                  ((abs_diff(word.pixel, prior_pixel) > cfg.edge_threshold) || last);
    run_len     = column - run_begin;
    accept      = run_end && ((CMP_W'(run_len) > CMP_W'(cfg.length_floor)) || last);
    merge       = have_prev_run &&
                  ({1'b0, abs_diff(begin_value, prev_run_end_value)} < cfg.join_threshold) &&
                  ((COL_W+1)'(run_begin) <= ((COL_W+1)'(prev_run_end) + (COL_W+1)'(1)));
    first       = merge ? prev_run_end : run_begin;
    valid       = accept && (first < column) && (cfg.intensity_floor <= INTENSITY_MAX);

    res.span_valid = valid;
    res.span_first = valid ? SPAN_W'(first) : '0;
    res.span_final = valid ? SPAN_W'(column - COL_W'(1)) : '0;
    res.row_done   = last;
    res_hit        = valid || last;
  end

  // Advance the row state by one pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column             <= '0;
      prior_pixel        <= '0;
      run_begin          <= '0;
      run_begin_value    <= '0;
      prev_run_end       <= '0;
      prev_run_end_value <= '0;
      have_prev_run      <= 1'b0;
    end else if (step) begin
      prior_pixel <= word.pixel;
      if (column == run_begin) begin
        run_begin_value <= word.pixel;
      end
      if (accept) begin
        prev_run_end       <= column;
        prev_run_end_value <= word.pixel;
      end
      if (last) begin
        column        <= '0;
        run_begin     <= '0;
        have_prev_run <= 1'b0;
      end else begin
        column <= column + COL_W'(1);
        if (run_end) begin
          run_begin <= column + COL_W'(1);
        end
        if (accept) begin
          have_prev_run <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/row_long_run_span_marker.sv */
// ----------------------------------------------------------------------------
// row_long_run_span_marker: reports spans of long flat runs in an image row
// Input register, per-pixel run logic and result register, one pixel a clock.
// ----------------------------------------------------------------------------
// Feed the pixels of a row left to right, one word per pixel, with row_last
// on the final pixel (a pixel at column MAX_WIDTH-1 also ends the row). The
// block takes one pixel per clock while the result register is not stalled.
// A pixel waits in the input register, passes the run logic and its result
// word is loaded into the result register; a result word that is not taken
// holds the next pixel in the input register. Each pixel passes the run-state
// update in the core once. A result word appears only when a span is to be
// cleared or the row ends; spans with columns above 4095 wrap to 12 bits.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module row_long_run_span_marker #(
  parameter int unsigned MAX_WIDTH = rlrsm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                px_valid,
  output logic                                px_ready,
  input  rlrsm_pkg::in_t                      px_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rlrsm_pkg::out_t                     res_data,
  input  logic                                cfg_we,
  input  logic [rlrsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlrsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rlrsm_pkg::*;

  cfg_t  cfg;
  logic  hold_valid;
  in_t   hold_word;
  logic  advance;
  out_t  core_res;
  logic  core_hit;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length_floor    <= LENGTH_FLOOR_RST;
      cfg.intensity_floor <= INTENSITY_FLOOR_RST;
      cfg.edge_threshold  <= EDGE_THRESHOLD_RST;
      cfg.join_threshold  <= JOIN_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LENGTH_FLOOR:    cfg.length_floor    <= cfg_data;
        CFG_INTENSITY_FLOOR: cfg.intensity_floor <= cfg_data[THR_W-1:0];
        CFG_EDGE_THRESHOLD:  cfg.edge_threshold  <= cfg_data[PIX_W-1:0];
        CFG_JOIN_THRESHOLD:  cfg.join_threshold  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Move the held word into the core when the result register is free
  assign advance  = hold_valid && (!res_valid || res_ready);
  assign px_ready = !hold_valid || advance;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (px_ready) begin
      hold_valid <= px_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (px_ready && px_valid) begin
      hold_word <= px_data;
    end
  end

  rlrsm_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .word    (hold_word),
    .cfg     (cfg),
    .res     (core_res),
    .res_hit (core_hit)
  );

  // Load the result register, drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= core_hit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_hit) begin
      res_data <= core_res;
    end
  end

`ifndef NO_ASSERTIONS
  // A held word that cannot advance stays put
  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_word))
    else $error("held pixel word lost or changed while stalled");

  // A result word carries a span or marks the row end
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.span_valid || res_data.row_done)
    else $error("result word with neither span nor row end");

  // A result without a span has zero columns
  a_no_span_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.span_valid |->
      res_data.span_first == '0 && res_data.span_final == '0)
    else $error("span columns set on a result without a span");

  // A span runs forward when columns fit the result fields
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.span_valid && (MAX_WIDTH <= 4096) |->
      res_data.span_first <= res_data.span_final)
    else $error("span ends before it begins");
`endif

endmodule

/* test/span_check.sv */
// ----------------------------------------------------------------------------
// span_check: result checker for the row long-run span marker
// Snoops the pixel, result and configuration ports, keeps its own copy of the
// row state, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module span_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             px_valid,
  input  logic                             px_ready,
  input  rlrsm_pkg::in_t                   px_data,
  input  logic                             res_valid,
  input  logic                             res_ready,
  input  rlrsm_pkg::out_t                  res_data,
  input  logic                             cfg_we,
  input  logic [rlrsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlrsm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               results,
  output int                               spans
);
  import rlrsm_pkg::*;

  localparam int ROW_MAX = int'(MAX_WIDTH_DEF);

  // Shadow registers and row state
  cfg_t              cfg;
  logic [SPAN_W-1:0] col;
  logic [LEN_W-1:0]  run_start;
  logic [PIX_W-1:0]  prev_px;
  logic [PIX_W-1:0]  run_start_px;
  logic [SPAN_W-1:0] joint_col;
  logic [PIX_W-1:0]  joint_px;
  bit                joint_seen;

  out_t expected_spans[$];

  function automatic int pix_gap(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("span check: %s is %0d, predicted %0d (t=%0t)", field, got, want, $realtime);
    errors++;
  endtask

  // Advance the row state by one pixel and queue the result word it causes
  task automatic step_row(input in_t w);
    logic [PIX_W-1:0] px;
    bit               last;
    bit               steep;
    bit               take;
    bit               merge;
    bit               hit;
    int               first_col;
    out_t             r;
    px        = w.pixel;
    last      = w.row_last || (int'(col) >= ROW_MAX - 1);
    hit       = 1'b0;
    first_col = 0;
    r         = '0;
    if (int'(col) == int'(run_start)) begin
      run_start_px = px;
    end
    if (col != '0) begin
      steep = pix_gap(px, prev_px) > int'(cfg.edge_threshold);
      if (steep || last) begin
        take = ((int'(col) - int'(run_start)) > int'(cfg.length_floor)) || last;
        if (take) begin
          // Pull the joint pixel in when it touches this run and matches
          merge = joint_seen
                  && (pix_gap(run_start_px, joint_px) < int'(cfg.join_threshold))
                  && (int'(run_start) <= int'(joint_col) + 1);
          first_col = merge ? int'(joint_col) : int'(run_start);
          if ((first_col < int'(col)) && (cfg.intensity_floor <= INTENSITY_MAX)) begin
            hit          = 1'b1;
            r.span_first = first_col[SPAN_W-1:0];
            r.span_final = col - SPAN_W'(1);
          end
          joint_seen = 1'b1;
          joint_col  = col;
          joint_px   = px;
        end
        run_start = LEN_W'(col) + LEN_W'(1);
      end
    end
    if (hit || last) begin
      r.span_valid = hit;
      r.row_done   = last;
      expected_spans = {expected_spans, r};
    end
    prev_px = px;
    if (last) begin
      col        = '0;
      run_start  = '0;
      joint_seen = 1'b0;
    end else begin
      col = col + SPAN_W'(1);
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      cfg.length_floor    = LENGTH_FLOOR_RST;
      cfg.intensity_floor = INTENSITY_FLOOR_RST;
      cfg.edge_threshold  = EDGE_THRESHOLD_RST;
      cfg.join_threshold  = JOIN_THRESHOLD_RST;
      col          = '0;
      run_start    = '0;
      prev_px      = '0;
      run_start_px = '0;
      joint_col    = '0;
      joint_px     = '0;
      joint_seen   = 1'b0;
      expected_spans.delete();
      errors  = 0;
      results = 0;
      spans   = 0;
    end else begin
      // Check the result word against the oldest prediction
      if (res_valid && res_ready) begin
        if (expected_spans.size() == 0) begin
          report_mismatch("unpredicted result word, row_done", int'(res_data.row_done), 0);
        end else begin
          want = expected_spans.pop_front();
          results++;
          if (want.span_valid) begin
            spans++;
          end
          if (res_data.span_valid !== want.span_valid) begin
            report_mismatch("span_valid", int'(res_data.span_valid), int'(want.span_valid));
          end
          if (res_data.span_first !== want.span_first) begin
            report_mismatch("span_first", int'(res_data.span_first), int'(want.span_first));
          end
          if (res_data.span_final !== want.span_final) begin
            report_mismatch("span_final", int'(res_data.span_final), int'(want.span_final));
          end
          if (res_data.row_done !== want.row_done) begin
            report_mismatch("row_done", int'(res_data.row_done), int'(want.row_done));
          end
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH_FLOOR:    cfg.length_floor    = cfg_data[LEN_W-1:0];
          CFG_INTENSITY_FLOOR: cfg.intensity_floor = cfg_data[THR_W-1:0];
          CFG_EDGE_THRESHOLD:  cfg.edge_threshold  = cfg_data[PIX_W-1:0];
          CFG_JOIN_THRESHOLD:  cfg.join_threshold  = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      // Predict from the accepted pixel word
      if (px_valid && px_ready) begin
        step_row(px_data);
      end
    end
    pending = expected_spans.size();
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the row long-run span marker
// Drives directed and random image rows under several register settings,
// with bursty pixel input and a stalling result sink; span_check predicts.
// ----------------------------------------------------------------------------
module testbench;
  import rlrsm_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 300;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  px_valid  = 1'b0;
  logic                  px_ready;
  in_t                   px_data   = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  out_t                  res_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int errors;
  int pending;
  int results;
  int spans;
  int words_sent = 0;
  int cycles     = 0;
  int burst_left = 0;
  int settings   = 0;
  bit hold_done  = 1'b0;

  // Directed rows: one pixel, joined runs, empty runs, edges only, clearing off
  logic [PIX_W-1:0] dir_px [0:23] = '{
    8'd77,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
    8'd10, 8'd10, 8'd10, 8'd200, 8'd10,
    8'd0, 8'd255, 8'd0, 8'd255,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5
  };
  localparam logic [23:0] DIR_LAST = (24'd1 << 0) | (24'd1 << 9) | (24'd1 << 14)
                                   | (24'd1 << 18) | (24'd1 << 23);

  row_long_run_span_marker i_dut (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px_ready  (px_ready),
    .px_data   (px_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  span_check i_check (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px_ready  (px_ready),
    .px_data   (px_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .results   (results),
    .spans     (spans)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(int ml, int mi, int et, int jt);
    write_reg(CFG_LENGTH_FLOOR, ml);
    write_reg(CFG_INTENSITY_FLOOR, mi);
    write_reg(CFG_EDGE_THRESHOLD, et);
    write_reg(CFG_JOIN_THRESHOLD, jt);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Drop valid and wait until every predicted word is out and the pipe is empty
  task automatic drain();
    px_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Offer one pixel word; open a new burst, maybe after a gap, when one runs out
  task automatic send_word(logic [PIX_W-1:0] p, bit last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        px_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    px_valid         <= 1'b1;
    px_data.pixel    <= p;
    px_data.row_last <= last;
    @(posedge clk);
    while (!px_ready) @(posedge clk);
    words_sent++;
  endtask

  // Send a row of flat stretches with small wiggle and occasional jumps
  task automatic send_row(int len, int jump_pct, int wiggle, bit mark_last);
    int level;
    level = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < jump_pct) begin
        level = $urandom_range(0, 255);
      end else begin
        level = level + $urandom_range(0, 2 * wiggle) - wiggle;
        if (level < 0) level = 0;
        if (level > 255) level = 255;
      end
      send_word(level[PIX_W-1:0], mark_last && (i == len - 1));
    end
  endtask

  // Random rows, mostly short, now and then long or pure noise
  task automatic run_rows(int words);
    int sent;
    int len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      if ($urandom_range(0, 7) == 0) begin
        send_row(len, 100, 0, 1'b1);
      end else begin
        send_row(len, $urandom_range(2, 30), $urandom_range(0, 8), 1'b1);
      end
      sent += len;
    end
    drain();
  endtask

  // Result sink: stall patterns in chunks, one long hold-off to back up the block
  initial begin : sink
    int mode;
    int chunk;
    forever begin
      if (!hold_done && words_sent >= HOLD_AT) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode  = $urandom_range(0, 3);
      chunk = $urandom_range(1, 64);
      repeat (chunk) begin
        case (mode)
          0:       res_ready <= 1'b1;
          1:       res_ready <= 1'($urandom_range(0, 1));
          2:       res_ready <= ($urandom_range(0, 3) != 0);
          default: res_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stim
    int ml;
    int mi;
    int et;
    int jt;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    set_config(2, 0, 50, 150);
    for (int i = 0; i < 24; i++) begin
      if (i == 19) begin
        drain();
        set_config(2, 256, 50, 150);
      end
      send_word(dir_px[i], DIR_LAST[i]);
    end
    drain();

    // Random rows over fixed and random settings
    set_config(15, 0, 50, 150);
    run_rows(115);
    set_config(0, 0, 0, 256);
    run_rows(115);
    set_config(4096, 255, 255, 0);
    run_rows(115);
    set_config(5, 256, 30, 100);
    run_rows(115);
    set_config(3, 511, 20, 511);
    run_rows(115);
    repeat (4) begin
      ml = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 24);
      mi = ($urandom_range(0, 4) == 0) ? $urandom_range(256, 511) : $urandom_range(0, 255);
      et = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      jt = $urandom_range(0, 511);
      set_config(ml, mi, et, jt);
      run_rows(115);
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d pixel words, %0d result words (%0d with a span), %0d settings.",
             words_sent, results, spans, settings);
    $display("It included one-pixel rows, empty and joined runs, disabled clearing %s",
             "and a long result stall.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rlrsm_pkg.sv
sv/rlrsm_core.sv
sv/row_long_run_span_marker.sv
test/span_check.sv
test/testbench.sv
